// ----- rtl/rau_pkg.sv -----
// Rational arithmetic unit package: transaction structs, mode and status codes,
// sequencer states. No dependencies.
package rau_pkg;

    localparam int NUM_W = 32;
    localparam int DEN_W = NUM_W - 1;
    localparam int PROD_W = 2 * NUM_W;
    localparam int CNT_W = 6;
    localparam int SHIFT_W = 7;

    typedef enum logic [3:0] {
        MODE_ADD = 4'd0,
        MODE_SUB = 4'd1,
        MODE_MUL = 4'd2,
        MODE_DIV = 4'd3,
        MODE_LESS = 4'd4,
        MODE_EQUAL = 4'd5,
        MODE_NEG = 4'd6,
        MODE_ABS = 4'd7,
        MODE_TO_INT = 4'd8
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_NOT_INT = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_COMBINE,
        S_ABS,
        S_GCD,
        S_DIVIDE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [3:0]              mode;
        logic signed [NUM_W-1:0] a_num;
        logic [DEN_W-1:0]        a_den;
        logic signed [NUM_W-1:0] b_num;
        logic [DEN_W-1:0]        b_den;
    } t_rau_in;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    compare_true;
        logic [1:0]              status;
    } t_rau_out;

endpackage

// ----- rtl/rational_arithmetic_unit.sv -----
// Rational arithmetic unit top level: sequencer around one 32x32 multiplier,
// 64-bit subtract/compare logic for binary gcd, and a restoring divider.
// Depends on rau_pkg.
//
// One transaction is accepted when start is high and busy is low; busy then
// stays high until the result is shown on o_result for one cycle with o_done.
// The receiver cannot stall. Errors and unused modes go from S_CHECK straight to
// S_FINISH; compares pass through S_MUL and S_COMBINE; arithmetic runs a binary
// gcd over the 64-bit numerator and denominator, then two exact divisions by
// the gcd, numerator first and denominator second.
module rational_arithmetic_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  rau_pkg::t_rau_in  i_cmd,
    output logic              busy,
    output logic              o_done,
    output rau_pkg::t_rau_out o_result
);

    localparam int PW = rau_pkg::PROD_W;
    localparam int NW = rau_pkg::NUM_W;
    localparam int DW = rau_pkg::DEN_W;

    rau_pkg::t_state r_state, n_state;
    rau_pkg::t_rau_in r_in, n_in;
    logic [rau_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_p0, n_p0, r_p1, n_p1;
    logic signed [PW:0] r_sum, n_sum;
    logic r_nneg, n_nneg;
    logic [PW-1:0] r_nmag, n_nmag, r_dmag, n_dmag;
    logic [PW-1:0] r_x, n_x, r_y, n_y;
    logic [rau_pkg::SHIFT_W-1:0] r_k, n_k;
    logic [PW-1:0] r_g, n_g;
    logic [PW-1:0] r_rem, n_rem, r_quo, n_quo;
    logic r_second, n_second;
    logic [1:0] r_st, n_st;
    logic r_cmp, n_cmp;
    logic r_arith, n_arith;
    logic n_done;
    rau_pkg::t_rau_out n_result;

    logic [NW-1:0] a_mag, b_mag;
    logic a_neg, b_neg;
    logic [NW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic signed [PW:0] s0, s1;
    logic [PW:0] rem2;
    logic ge;
    logic [PW-1:0] fin_d;
    logic fin_neg, fin_ovf;
    logic [1:0] fin_st;

    assign a_neg = r_in.a_num[NW-1];
    assign b_neg = r_in.b_num[NW-1];
    assign a_mag = a_neg ? (~r_in.a_num + 1'b1) : r_in.a_num;
    assign b_mag = b_neg ? (~r_in.b_num + 1'b1) : r_in.b_num;

    always_comb begin
        mul_a = a_mag;
        mul_b = {1'b0, r_in.b_den};
        case (r_cnt[1:0])
            2'd0: begin
                if (r_in.mode == rau_pkg::MODE_MUL) begin
                    mul_b = b_mag;
                end
            end
            2'd1: begin
                mul_a = b_mag;
                mul_b = {1'b0, r_in.a_den};
            end
            default: begin
                mul_a = {1'b0, r_in.a_den};
                mul_b = (r_in.mode == rau_pkg::MODE_DIV) ? b_mag : {1'b0, r_in.b_den};
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    always_comb begin
        s0 = a_neg ? -$signed({1'b0, r_p0}) : $signed({1'b0, r_p0});
        s1 = ((r_in.mode == rau_pkg::MODE_SUB) ^ b_neg) ?
             -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
    end

    assign rem2 = {r_rem, r_quo[PW-1]};
    assign ge = rem2 >= {1'b0, r_g};

    always_comb begin
        fin_neg = r_nneg && (r_nmag != '0);
        fin_d = (r_nmag == '0) ? PW'(1) : r_dmag;
        fin_ovf = (fin_neg ? (r_nmag > (PW'(1) << (NW - 1)))
                           : (r_nmag > ((PW'(1) << (NW - 1)) - 1'b1)))
                  || (fin_d > ((PW'(1) << DW) - 1'b1));
        if (r_st != rau_pkg::ST_OK) begin
            fin_st = r_st;
        end else if (!r_arith) begin
            fin_st = rau_pkg::ST_OK;
        end else if (r_in.mode == rau_pkg::MODE_TO_INT && fin_d != PW'(1)) begin
            fin_st = rau_pkg::ST_NOT_INT;
        end else if (fin_ovf) begin
            fin_st = rau_pkg::ST_OVERFLOW;
        end else begin
            fin_st = rau_pkg::ST_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        n_in = r_in;
        n_cnt = r_cnt;
        n_p0 = r_p0;
        n_p1 = r_p1;
        n_sum = r_sum;
        n_nneg = r_nneg;
        n_nmag = r_nmag;
        n_dmag = r_dmag;
        n_x = r_x;
        n_y = r_y;
        n_k = r_k;
        n_g = r_g;
        n_rem = r_rem;
        n_quo = r_quo;
        n_second = r_second;
        n_st = r_st;
        n_cmp = r_cmp;
        n_arith = r_arith;
        n_done = 1'b0;
        n_result = o_result;
        case (r_state)
            rau_pkg::S_IDLE: begin
                if (start) begin
                    n_in = i_cmd;
                    n_st = rau_pkg::ST_OK;
                    n_cmp = 1'b0;
                    n_arith = 1'b0;
                    n_cnt = '0;
                    n_state = rau_pkg::S_CHECK;
                end
            end
            rau_pkg::S_CHECK: begin
                if (r_in.mode > rau_pkg::MODE_TO_INT) begin
                    n_state = rau_pkg::S_FINISH;
                end else if (r_in.a_den == '0
                             || (r_in.mode <= rau_pkg::MODE_EQUAL && r_in.b_den == '0)
                             || (r_in.mode == rau_pkg::MODE_DIV && r_in.b_num == '0)) begin
                    n_st = rau_pkg::ST_DIV_ZERO;
                    n_state = rau_pkg::S_FINISH;
                end else if (r_in.mode >= rau_pkg::MODE_NEG) begin
                    n_nmag = PW'(a_mag);
                    n_dmag = PW'(r_in.a_den);
                    n_nneg = (r_in.mode == rau_pkg::MODE_NEG) ? !a_neg :
                             (r_in.mode == rau_pkg::MODE_ABS) ? 1'b0 : a_neg;
                    n_x = PW'(a_mag);
                    n_y = PW'(r_in.a_den);
                    n_k = '0;
                    n_arith = 1'b1;
                    n_state = rau_pkg::S_GCD;
                end else begin
                    n_state = rau_pkg::S_MUL;
                end
            end
            rau_pkg::S_MUL: begin
                n_cnt = r_cnt + 1'b1;
                case (r_cnt[1:0])
                    2'd0: n_p0 = mul_p;
                    2'd1: n_p1 = mul_p;
                    default: begin
                        n_dmag = mul_p;
                        n_state = rau_pkg::S_COMBINE;
                    end
                endcase
            end
            rau_pkg::S_COMBINE: begin
                n_sum = s0 + s1;
                if (r_in.mode == rau_pkg::MODE_LESS) begin
                    n_cmp = s0 < s1;
                    n_state = rau_pkg::S_FINISH;
                end else if (r_in.mode == rau_pkg::MODE_EQUAL) begin
                    n_cmp = s0 == s1;
                    n_state = rau_pkg::S_FINISH;
                end else if (r_in.mode == rau_pkg::MODE_MUL
                             || r_in.mode == rau_pkg::MODE_DIV) begin
                    n_nneg = a_neg ^ b_neg;
                    n_nmag = r_p0;
                    n_x = r_p0;
                    n_y = r_dmag;
                    n_k = '0;
                    n_arith = 1'b1;
                    n_state = rau_pkg::S_GCD;
                end else begin
                    n_state = rau_pkg::S_ABS;
                end
            end
            rau_pkg::S_ABS: begin
                n_nneg = r_sum[PW];
                n_nmag = r_sum[PW] ? PW'(-r_sum) : r_sum[PW-1:0];
                n_x = n_nmag;
                n_y = r_dmag;
                n_k = '0;
                n_arith = 1'b1;
                n_state = rau_pkg::S_GCD;
            end
            rau_pkg::S_GCD: begin
                if (r_y == '0 || r_x == '0) begin
                    n_g = (r_y == '0 ? r_x : r_y) << r_k;
                    n_rem = '0;
                    n_quo = r_nmag;
                    n_cnt = '0;
                    n_second = 1'b0;
                    n_state = rau_pkg::S_DIVIDE;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x >= r_y) begin
                    n_x = r_x - r_y;
                end else begin
                    n_y = r_y - r_x;
                end
            end
            rau_pkg::S_DIVIDE: begin
                n_rem = ge ? PW'(rem2 - {1'b0, r_g}) : rem2[PW-1:0];
                n_quo = {r_quo[PW-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    if (!r_second) begin
                        n_nmag = n_quo;
                        n_rem = '0;
                        n_quo = r_dmag;
                        n_second = 1'b1;
                    end else begin
                        n_dmag = n_quo;
                        n_state = rau_pkg::S_FINISH;
                    end
                end
            end
            rau_pkg::S_FINISH: begin
                n_done = 1'b1;
                n_result.status = fin_st;
                n_result.compare_true = (fin_st == rau_pkg::ST_OK) && r_cmp;
                if (fin_st == rau_pkg::ST_OK && r_arith) begin
                    n_result.res_num = fin_neg ? -r_nmag[NW-1:0] : r_nmag[NW-1:0];
                    n_result.res_den = fin_d[DW-1:0];
                end else begin
                    n_result.res_num = '0;
                    n_result.res_den = DW'(1);
                end
                n_state = rau_pkg::S_IDLE;
            end
            default: n_state = rau_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
            o_done <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_cnt <= n_cnt;
        r_p0 <= n_p0;
        r_p1 <= n_p1;
        r_sum <= n_sum;
        r_nneg <= n_nneg;
        r_nmag <= n_nmag;
        r_dmag <= n_dmag;
        r_x <= n_x;
        r_y <= n_y;
        r_k <= n_k;
        r_g <= n_g;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_second <= n_second;
        r_st <= n_st;
        r_cmp <= n_cmp;
        r_arith <= n_arith;
        o_result <= n_result;
    end

    assign busy = (r_state != rau_pkg::S_IDLE);

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status != rau_pkg::ST_OK |->
        o_result.res_num == '0 && o_result.res_den == DW'(1) && !o_result.compare_true)
        else $error("error result carries a value");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rau_pkg::S_DIVIDE |-> r_g != '0)
        else $error("zero gcd");

endmodule
